@@ rtl/csim_pkg.sv @@
// Shared widths, register indexes and reset values for the curvature-selected info matrix.
package csim_pkg;

  // Field widths
  localparam int EvW     = 16;  // eigenvector entry, Q1.14
  localparam int CurvW   = 16;  // curvature, Q0.16
  localparam int EntryW  = 16;  // matrix entry, Q8.8
  localparam int RowW    = 3 * EntryW;
  localparam int InfoW   = 32;  // result, Q16.16
  localparam int CfgIdxW = 3;

  // Datapath widths: U*M products, three-term row sums, second products, rounded sums
  localparam int ProdW   = EvW + EntryW;
  localparam int WSumW   = ProdW + 2;
  localparam int Prod2W  = WSumW + EvW;
  localparam int AccW    = Prod2W + 3;
  localparam int DropW   = 20;  // 36 fraction bits down to 16
  localparam int RndW    = AccW - DropW;

  localparam logic [AccW-1:0] RoundBias = AccW'(1) << (DropW - 1);

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFlat0     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFlat1     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFlat2     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCurved0   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCurved1   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCurved2   = 3'd6;

  localparam logic [CurvW-1:0] ThresholdReset = 16'd1311;

  typedef logic [RowW-1:0] row_t;

endpackage

@@ rtl/curvature_selected_info_matrix.sv @@
// Curvature-selected information matrix: R = U * M * U^T over a five-stage pipeline.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------------
//  in      | sink      | in_valid_i / in_ready_o    | ev_00_i..ev_22_i, point_curvature_i,
//          |           |                            | normal_valid_i
//  out     | source    | out_valid_o / out_ready_i  | info_00_o..info_22_o
//  cfg     | sink      | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// Flow: one beat enters per cycle while in_ready_o is high; a result passes through five
//   register stages (two multiply stages, two three-term adder stages and the output
//   register) before it is offered.
// Reset: valid bits clear, threshold returns to 1311, both matrices return to zero.
// Stalls: the whole pipeline holds while a result waits and out_ready_i is low; bubbles
//   advance otherwise, so in_ready_o stays high whenever the output register is free
//   or is being emptied.
module curvature_selected_info_matrix (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [csim_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [csim_pkg::RowW-1:0]          cfg_wdata_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [csim_pkg::EvW-1:0]    ev_00_i,
  input  logic signed [csim_pkg::EvW-1:0]    ev_01_i,
  input  logic signed [csim_pkg::EvW-1:0]    ev_02_i,
  input  logic signed [csim_pkg::EvW-1:0]    ev_10_i,
  input  logic signed [csim_pkg::EvW-1:0]    ev_11_i,
  input  logic signed [csim_pkg::EvW-1:0]    ev_12_i,
  input  logic signed [csim_pkg::EvW-1:0]    ev_20_i,
  input  logic signed [csim_pkg::EvW-1:0]    ev_21_i,
  input  logic signed [csim_pkg::EvW-1:0]    ev_22_i,
  input  logic [csim_pkg::CurvW-1:0]         point_curvature_i,
  input  logic                               normal_valid_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [csim_pkg::InfoW-1:0]  info_00_o,
  output logic signed [csim_pkg::InfoW-1:0]  info_01_o,
  output logic signed [csim_pkg::InfoW-1:0]  info_02_o,
  output logic signed [csim_pkg::InfoW-1:0]  info_10_o,
  output logic signed [csim_pkg::InfoW-1:0]  info_11_o,
  output logic signed [csim_pkg::InfoW-1:0]  info_12_o,
  output logic signed [csim_pkg::InfoW-1:0]  info_20_o,
  output logic signed [csim_pkg::InfoW-1:0]  info_21_o,
  output logic signed [csim_pkg::InfoW-1:0]  info_22_o
);

  import csim_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CurvW-1:0] thresh_q;
  row_t             flat_q   [3];
  row_t             curved_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThresholdReset;
      for (int r = 0; r < 3; r++) begin
        flat_q[r]   <= '0;
        curved_q[r] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegThreshold: thresh_q    <= cfg_wdata_i[CurvW-1:0];
        RegFlat0:     flat_q[0]   <= cfg_wdata_i;
        RegFlat1:     flat_q[1]   <= cfg_wdata_i;
        RegFlat2:     flat_q[2]   <= cfg_wdata_i;
        RegCurved0:   curved_q[0] <= cfg_wdata_i;
        RegCurved1:   curved_q[1] <= cfg_wdata_i;
        RegCurved2:   curved_q[2] <= cfg_wdata_i;
        default: ;  // index beyond the list: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: every stage advances together whenever the output register
  // is empty or its beat is being taken.
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_vld_q;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Gather the input beat into an array for the loops below
  logic signed [EvW-1:0] u_in [3][3];
  assign u_in[0][0] = ev_00_i;
  assign u_in[0][1] = ev_01_i;
  assign u_in[0][2] = ev_02_i;
  assign u_in[1][0] = ev_10_i;
  assign u_in[1][1] = ev_11_i;
  assign u_in[1][2] = ev_12_i;
  assign u_in[2][0] = ev_20_i;
  assign u_in[2][1] = ev_21_i;
  assign u_in[2][2] = ev_22_i;

  // Pick the flat matrix when the curvature is strictly below the threshold;
  // a tie counts as curved.
  logic                     is_flat;
  logic signed [EntryW-1:0] m_sel [3][3];

  assign is_flat = point_curvature_i < thresh_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int l = 0; l < 3; l++) begin
        m_sel[k][l] = is_flat ? $signed(flat_q[k][EntryW*l +: EntryW])
                              : $signed(curved_q[k][EntryW*l +: EntryW]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: products U[i][k] * M[k][l]
  // ---------------------------------------------------------------------------
  logic                    s1_vld_q, s1_nv_q;
  logic signed [EvW-1:0]   s1_u_q [3][3];
  logic signed [ProdW-1:0] s1_p_q [3][3][3];  // [i][k][l]

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_nv_q <= normal_valid_i;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          s1_u_q[i][k] <= u_in[i][k];
          for (int l = 0; l < 3; l++) begin
            s1_p_q[i][k][l] <= ProdW'(u_in[i][k]) * ProdW'(m_sel[k][l]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: W = U * M, summing over k
  // ---------------------------------------------------------------------------
  logic                    s2_vld_q, s2_nv_q;
  logic signed [EvW-1:0]   s2_u_q [3][3];
  logic signed [WSumW-1:0] s2_w_q [3][3];     // [i][l]

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_nv_q <= s1_nv_q;
      for (int i = 0; i < 3; i++) begin
        for (int l = 0; l < 3; l++) begin
          s2_u_q[i][l] <= s1_u_q[i][l];
          s2_w_q[i][l] <= WSumW'(s1_p_q[i][0][l]) + WSumW'(s1_p_q[i][1][l])
                        + WSumW'(s1_p_q[i][2][l]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: products W[i][l] * U[j][l]
  // ---------------------------------------------------------------------------
  logic                     s3_vld_q, s3_nv_q;
  logic signed [Prod2W-1:0] s3_p_q [3][3][3]; // [i][j][l]

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_nv_q <= s2_nv_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int l = 0; l < 3; l++) begin
            s3_p_q[i][j][l] <= Prod2W'(s2_w_q[i][l]) * Prod2W'(s2_u_q[j][l]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: exact sum over l with the half-LSB rounding bias folded in
  // ---------------------------------------------------------------------------
  logic                   s4_vld_q, s4_nv_q;
  logic signed [AccW-1:0] s4_acc_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (adv) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_nv_q <= s3_nv_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s4_acc_q[i][j] <= AccW'(s3_p_q[i][j][0]) + AccW'(s3_p_q[i][j][1])
                          + AccW'(s3_p_q[i][j][2]) + $signed(RoundBias);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: drop the low fraction bits (floor of the biased sum, so round to
  // nearest), saturate to 32 bits, and force zero for an invalid normal.
  logic signed [RndW-1:0]  rnd   [3][3];
  logic signed [InfoW-1:0] sat_d [3][3];
  logic signed [InfoW-1:0] info_q [3][3];
  logic                    out_nv_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rnd[i][j] = s4_acc_q[i][j][AccW-1:DropW];
        if (!s4_nv_q) begin
          sat_d[i][j] = '0;
        end else if (rnd[i][j] > $signed(RndW'({1'b0, {(InfoW-1){1'b1}}}))) begin
          sat_d[i][j] = {1'b0, {(InfoW-1){1'b1}}};
        end else if (rnd[i][j] < -$signed(RndW'({1'b0, {(InfoW-1){1'b1}}})) - RndW'(1)) begin
          sat_d[i][j] = {1'b1, {(InfoW-1){1'b0}}};
        end else begin
          sat_d[i][j] = rnd[i][j][InfoW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_nv_q <= s4_nv_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          info_q[i][j] <= sat_d[i][j];
        end
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign info_00_o   = info_q[0][0];
  assign info_01_o   = info_q[0][1];
  assign info_02_o   = info_q[0][2];
  assign info_10_o   = info_q[1][0];
  assign info_11_o   = info_q[1][1];
  assign info_12_o   = info_q[1][2];
  assign info_20_o   = info_q[2][0];
  assign info_21_o   = info_q[2][1];
  assign info_22_o   = info_q[2][2];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A beat leaving the last compute stage lands in the output register.
  a_last_stage_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_vld_q && in_ready_o |=> out_valid_o)
    else $error("stage 4 beat lost on its way to the output register");

  // A stall freezes the valid bits of the inner stages.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(s1_vld_q) && $stable(s2_vld_q) && $stable(s3_vld_q)
                    && $stable(s4_vld_q))
    else $error("pipeline moved during a stall");

  // A point without a valid normal yields an all-zero result.
  a_invalid_normal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_nv_q |-> info_00_o == '0 && info_01_o == '0 && info_02_o == '0
      && info_10_o == '0 && info_11_o == '0 && info_12_o == '0
      && info_20_o == '0 && info_21_o == '0 && info_22_o == '0)
    else $error("invalid normal gave a nonzero result");

endmodule
